FILE: hw/rtl/rbsi_pkg.sv
// Shared types and constants for the ray versus box slab test pipeline.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rbsi_pkg;

  // Direction is signed Q1.15, so quotients are scaled by 2^15.
  localparam int DIR_W    = 16;
  localparam int DIR_FRAC = 15;
  localparam int DEN_W    = 16;

  // Quotient bits produced by the divider before saturation.
  localparam int Q_W        = 33;
  localparam int STEP_BITS  = 3;
  localparam int N_STEPS    = Q_W / STEP_BITS;
  localparam int DIV_STAGES = N_STEPS + 2;

  localparam int DIST_W = 31;
  localparam int T_W    = 32;
  localparam int OUT_W  = 40;

  localparam logic [DIST_W-1:0] MAX_DIST_RESET = 31'd524288;

  localparam logic [Q_W-1:0] Q_POS_LIMIT = 33'h0_7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_NEG_LIMIT = 33'h0_8000_0000;
  localparam logic [T_W-1:0] T_POS_SAT   = 32'h7FFF_FFFF;
  localparam logic [T_W-1:0] T_NEG_SAT   = 32'h8000_0000;

  // Normal component codes.
  localparam logic [1:0] NORM_ZERO = 2'b00;
  localparam logic [1:0] NORM_POS  = 2'b01;
  localparam logic [1:0] NORM_NEG  = 2'b11;

  typedef logic signed [T_W-1:0] tval_t;

  typedef struct packed {
    tval_t t0;
    tval_t t1;
  } tpair_t;

  // Running interval and entry face while the axes are merged in turn.
  typedef struct packed {
    logic        miss;
    tval_t       entry;
    tval_t       exit_t;
    logic [5:0]  normal;
  } slab_state_t;

  // Per-item flags that travel beside the divider lanes.
  typedef struct packed {
    logic [2:0] dzero;
    logic       pmiss;
  } side_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ray_box_slab_intersect.sv
// Ray versus axis-aligned box slab test, fully pipelined over 18 register stages.
// Throughput: one beat per cycle while the result side accepts (m_tready_i).
// The 13-stage divider lanes set the depth.
// Reset clears every stage valid bit and sets max_distance to 8.0 (Q15.16).
// Depends on rbsi_pkg, rbsi_div_lane and rbsi_slab_merge.
`timescale 1ns / 1ps
`default_nettype none

module ray_box_slab_intersect #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  // Configuration: max_distance, unsigned Q15.16.
  input  wire logic                                     cfg_we_i,
  input  wire logic [rbsi_pkg::DIST_W-1:0]              cfg_wdata_i,
  // Input beat, fields from bit 0 up: origin_x, origin_y, origin_z, dir_x, dir_y,
  // dir_z, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z.
  input  wire logic                                     s_tvalid_i,
  output      logic                                     s_tready_o,
  input  wire logic [((9*COORD_WIDTH+48+7)/8)*8-1:0]    s_tdata_i,
  // Result beat, fields from bit 0 up: hit, distance, normal_x, normal_y,
  // normal_z, then two zero bits.
  output      logic                                     m_tvalid_o,
  input  wire logic                                     m_tready_i,
  output      logic [rbsi_pkg::OUT_W-1:0]               m_tdata_o
);
  import rbsi_pkg::*;

  localparam int CW       = COORD_WIDTH;
  localparam int MAG_W    = CW + 1;
  localparam int DIR_OFS  = 3 * CW;
  localparam int MIN_OFS  = 3 * CW + 3 * DIR_W;
  localparam int MAX_OFS  = 6 * CW + 3 * DIR_W;
  // Stage map: 0 prepare, 1..13 divide, 14..16 merge x, y, z, 17 output.
  localparam int MERGE0   = 1 + DIV_STAGES;
  localparam int OUT_STG  = MERGE0 + 3;
  localparam int N_STG    = OUT_STG + 1;

  logic [N_STG-1:0] v_q;
  logic [N_STG-1:0] en;

  logic [DIST_W-1:0] maxd_q;

  // Flow control: a stage may load when it is empty or its own content moves on.
  // Bubbles collapse, so inputs go in while a result waits until all stages fill.
  always_comb begin
    en[OUT_STG] = !v_q[OUT_STG] || m_tready_i;
    for (int i = OUT_STG - 1; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign s_tready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_tvalid_i;
      end
      for (int i = 1; i < N_STG; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxd_q <= MAX_DIST_RESET;
    end else if (cfg_we_i) begin
      maxd_q <= cfg_wdata_i;
    end
  end

  // Prepare stage: slab offsets, magnitudes, quotient signs and parallel-axis tests.
  logic [MAG_W-1:0] mag_d  [3][2];
  logic [DEN_W-1:0] dmag_d [3];
  logic             neg_d  [3][2];
  side_t            sb_d;

  logic [MAG_W-1:0] mag_q  [3][2];
  logic [DEN_W-1:0] dmag_q [3];
  logic             neg_q  [3][2];
  side_t            sb_q   [MERGE0+2];

  always_comb begin
    logic signed [CW-1:0]    org;
    logic signed [CW-1:0]    lo;
    logic signed [CW-1:0]    hi;
    logic signed [DIR_W-1:0] dir;
    logic signed [CW:0]      dlo;
    logic signed [CW:0]      dhi;
    sb_d = '0;
    for (int a = 0; a < 3; a++) begin
      org = s_tdata_i[a*CW +: CW];
      dir = s_tdata_i[DIR_OFS + a*DIR_W +: DIR_W];
      lo  = s_tdata_i[MIN_OFS + a*CW +: CW];
      hi  = s_tdata_i[MAX_OFS + a*CW +: CW];
      dlo = {lo[CW-1], lo} - {org[CW-1], org};
      dhi = {hi[CW-1], hi} - {org[CW-1], org};
      mag_d[a][0] = dlo[CW] ? MAG_W'(-dlo) : MAG_W'(dlo);
      mag_d[a][1] = dhi[CW] ? MAG_W'(-dhi) : MAG_W'(dhi);
      neg_d[a][0] = dlo[CW] ^ dir[DIR_W-1];
      neg_d[a][1] = dhi[CW] ^ dir[DIR_W-1];
      dmag_d[a]   = dir[DIR_W-1] ? DEN_W'(-dir) : DEN_W'(dir);
      sb_d.dzero[a] = (dir == '0);
      if ((dir == '0) && ((org < lo) || (org > hi))) begin
        sb_d.pmiss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mag_q  <= mag_d;
      dmag_q <= dmag_d;
      neg_q  <= neg_d;
      sb_q[0] <= sb_d;
    end
    for (int i = 1; i < MERGE0 + 2; i++) begin
      if (en[i]) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  // Six divider lanes: box_min and box_max quotient of each axis.
  tval_t  t_div [3][2];
  tpair_t tp_x;
  tpair_t tp_q  [2][3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    for (genvar k = 0; k < 2; k++) begin : g_lane
      rbsi_div_lane #(
        .MAG_W(MAG_W)
      ) u_div (
        .clk_i (clk_i),
        .en_i  (en[DIV_STAGES:1]),
        .mag_i (mag_q[a][k]),
        .den_i (dmag_q[a]),
        .neg_i (neg_q[a][k]),
        .quot_o(t_div[a][k])
      );
    end
  end

  assign tp_x = '{t0: t_div[0][0], t1: t_div[0][1]};

  // The y and z pairs wait beside the merge stages until their turn.
  always_ff @(posedge clk_i) begin
    if (en[MERGE0]) begin
      for (int a = 0; a < 3; a++) begin
        tp_q[0][a] <= '{t0: t_div[a][0], t1: t_div[a][1]};
      end
    end
    if (en[MERGE0+1]) begin
      tp_q[1] <= tp_q[0];
    end
  end

  // Axis merge chain in x, y, z order; the interval starts as [0, max_distance].
  slab_state_t st_init;
  slab_state_t st_x;
  slab_state_t st_y;
  slab_state_t st_z;

  assign st_init = '{miss: sb_q[MERGE0-1].pmiss, entry: '0,
                     exit_t: {1'b0, maxd_q}, normal: '0};

  rbsi_slab_merge u_merge_x (
    .clk_i     (clk_i),
    .en_i      (en[MERGE0]),
    .axis_sel_i(3'b001),
    .dzero_i   (sb_q[MERGE0-1].dzero[0]),
    .tp_i      (tp_x),
    .state_i   (st_init),
    .state_o   (st_x)
  );

  rbsi_slab_merge u_merge_y (
    .clk_i     (clk_i),
    .en_i      (en[MERGE0+1]),
    .axis_sel_i(3'b010),
    .dzero_i   (sb_q[MERGE0].dzero[1]),
    .tp_i      (tp_q[0][1]),
    .state_i   (st_x),
    .state_o   (st_y)
  );

  rbsi_slab_merge u_merge_z (
    .clk_i     (clk_i),
    .en_i      (en[MERGE0+2]),
    .axis_sel_i(3'b100),
    .dzero_i   (sb_q[MERGE0+1].dzero[2]),
    .tp_i      (tp_q[1][2]),
    .state_i   (st_y),
    .state_o   (st_z)
  );

  // Output register: a miss clears every field.
  logic [OUT_W-1:0] out_d;
  logic [OUT_W-1:0] out_q;

  always_comb begin
    if (st_z.miss) begin
      out_d = '0;
    end else begin
      out_d = {2'b00, st_z.normal, st_z.entry[DIST_W-1:0], 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OUT_STG]) begin
      out_q <= out_d;
    end
  end

  assign m_tvalid_o = v_q[OUT_STG];
  assign m_tdata_o  = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rbsi_div_lane.sv
// One pipelined restoring divider lane: |num| * 2^15 / |dir|, signed and saturated.
// Depends on rbsi_pkg; the stage enables come from the top-level flow control.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_div_lane #(
  parameter int MAG_W = 33
) (
  input  wire logic                               clk_i,
  input  wire logic [rbsi_pkg::DIV_STAGES-1:0]    en_i,
  input  wire logic [MAG_W-1:0]                   mag_i,
  input  wire logic [rbsi_pkg::DEN_W-1:0]         den_i,
  input  wire logic                               neg_i,
  output rbsi_pkg::tval_t                         quot_o
);
  import rbsi_pkg::*;

  localparam int AN_W  = MAG_W + DIR_FRAC;
  localparam int EXT_W = (AN_W > Q_W + 1) ? AN_W : Q_W + 1;
  localparam int TOP_W = EXT_W - Q_W;
  localparam int CMP_W = (TOP_W > DEN_W) ? TOP_W : DEN_W;

  logic [EXT_W-1:0] an_ext;
  logic [CMP_W-1:0] top_c;
  logic [CMP_W-1:0] den_c;
  logic             ovf;

  logic [DEN_W-1:0] rem_q  [N_STEPS+1];
  logic [Q_W-1:0]   num_q  [N_STEPS+1];
  logic [Q_W-1:0]   quot_q [N_STEPS+1];
  logic [DEN_W-1:0] den_q  [N_STEPS+1];
  logic             neg_q  [N_STEPS+1];
  logic             ovf_q  [N_STEPS+1];
  tval_t            res_q;
  tval_t            res_d;

  // Quotient bits above bit 32 are not formed; their presence is an overflow.
  assign an_ext = EXT_W'({mag_i, {DIR_FRAC{1'b0}}});
  assign top_c  = CMP_W'(an_ext[EXT_W-1:Q_W]);
  assign den_c  = CMP_W'(den_i);
  assign ovf    = top_c >= den_c;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0]  <= ovf ? '0 : top_c[DEN_W-1:0];
      num_q[0]  <= an_ext[Q_W-1:0];
      quot_q[0] <= '0;
      den_q[0]  <= den_i;
      neg_q[0]  <= neg_i;
      ovf_q[0]  <= ovf;
    end
  end

  for (genvar s = 1; s <= N_STEPS; s++) begin : g_step
    logic [DEN_W-1:0] rem_d;
    logic [Q_W-1:0]   num_d;
    logic [Q_W-1:0]   quot_d;

    always_comb begin
      logic [DEN_W:0] rx;
      rem_d  = rem_q[s-1];
      num_d  = num_q[s-1];
      quot_d = quot_q[s-1];
      for (int j = 0; j < STEP_BITS; j++) begin
        rx    = {rem_d, num_d[Q_W-1]};
        num_d = {num_d[Q_W-2:0], 1'b0};
        if (rx >= {1'b0, den_q[s-1]}) begin
          rx     = rx - {1'b0, den_q[s-1]};
          quot_d = {quot_d[Q_W-2:0], 1'b1};
        end else begin
          quot_d = {quot_d[Q_W-2:0], 1'b0};
        end
        rem_d = rx[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s]  <= rem_d;
        num_q[s]  <= num_d;
        quot_q[s] <= quot_d;
        den_q[s]  <= den_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
      end
    end
  end

  always_comb begin
    if (neg_q[N_STEPS]) begin
      if (ovf_q[N_STEPS] || (quot_q[N_STEPS] > Q_NEG_LIMIT)) begin
        res_d = T_NEG_SAT;
      end else begin
        res_d = -$signed(quot_q[N_STEPS][T_W-1:0]);
      end
    end else begin
      if (ovf_q[N_STEPS] || (quot_q[N_STEPS] > Q_POS_LIMIT)) begin
        res_d = T_POS_SAT;
      end else begin
        res_d = quot_q[N_STEPS][T_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[N_STEPS+1]) begin
      res_q <= res_d;
    end
  end

  assign quot_o = res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rbsi_slab_merge.sv
// One registered merge stage: folds one axis's slab pair into the running interval.
// Depends on rbsi_pkg for the state and pair types.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_slab_merge (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [2:0]            axis_sel_i,
  input  wire logic                  dzero_i,
  input  rbsi_pkg::tpair_t           tp_i,
  input  rbsi_pkg::slab_state_t      state_i,
  output rbsi_pkg::slab_state_t      state_o
);
  import rbsi_pkg::*;

  slab_state_t st_d;
  slab_state_t st_q;

  always_comb begin
    logic       swap;
    tval_t      lo;
    tval_t      hi;
    logic [1:0] code;
    st_d = state_i;
    swap = $signed(tp_i.t0) > $signed(tp_i.t1);
    lo   = swap ? tp_i.t1 : tp_i.t0;
    hi   = swap ? tp_i.t0 : tp_i.t1;
    code = swap ? NORM_POS : NORM_NEG;
    if (!dzero_i) begin
      if ($signed(lo) > $signed(state_i.entry)) begin
        st_d.entry = lo;
        for (int k = 0; k < 3; k++) begin
          st_d.normal[2*k +: 2] = axis_sel_i[k] ? code : NORM_ZERO;
        end
      end
      if ($signed(hi) < $signed(state_i.exit_t)) begin
        st_d.exit_t = hi;
      end
      if ($signed(st_d.entry) > $signed(st_d.exit_t)) begin
        st_d.miss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign state_o = st_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rbsi_checker.sv
// Port-level checks on the result stream of the slab test, and their bind.
// Depends on rbsi_pkg for the result layout; attaches to ray_box_slab_intersect.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          m_tvalid_i,
  input  wire logic                          m_tready_i,
  input  wire logic [rbsi_pkg::OUT_W-1:0]    m_tdata_i
);
  import rbsi_pkg::*;

  // A stalled result beat keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result beat changed while stalled");

  // A miss carries no distance and no normal.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tdata_i[0] |-> m_tdata_i == '0)
    else $error("miss beat with non-zero fields");

  // A hit at distance zero has no entry face; a farther hit has exactly one.
  a_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[0] |->
      ((m_tdata_i[31:1] == '0) ? (m_tdata_i[39:32] == '0)
        : $onehot({m_tdata_i[33:32] != NORM_ZERO, m_tdata_i[35:34] != NORM_ZERO,
                   m_tdata_i[37:36] != NORM_ZERO})))
    else $error("entry face inconsistent with distance");

  // Normal components are only -1, 0 or +1.
  a_norm_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> m_tdata_i[33:32] != 2'b10 && m_tdata_i[35:34] != 2'b10 &&
                   m_tdata_i[37:36] != 2'b10)
    else $error("invalid normal code");

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .m_tvalid_i(m_tvalid_o),
  .m_tready_i(m_tready_i),
  .m_tdata_i (m_tdata_o)
);

`default_nettype wire
